// ===== rtl/e2c_pkg.sv =====
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared constants and the pipeline stage record for the epoch seconds to
// calendar unit.
// ----------------------------------------------------------------------------
package e2c_pkg;

    localparam int NUM_STAGES = 14;

    localparam logic signed [4:0] ZONE_RESET = 5'sd8;

    // Divisors.
    localparam logic [5:0]  DIV_60     = 6'd60;
    localparam logic [4:0]  DIV_24     = 5'd24;
    localparam logic [17:0] DIV_146097 = 18'd146097;
    localparam logic [10:0] DIV_1461   = 11'd1461;
    localparam logic [7:0]  DIV_153    = 8'd153;

    // Truncated reciprocals, floor(2^s / divisor), for the shift s of each use.
    localparam logic [26:0] RECIP_60_S32     = 27'd71582788;
    localparam logic [21:0] RECIP_60_S27     = 22'd2236962;
    localparam logic [16:0] RECIP_24_S21     = 17'd87381;
    localparam logic [6:0]  RECIP_146097_S24 = 7'd114;
    localparam logic [7:0]  RECIP_1461_S18   = 8'd179;
    localparam logic [3:0]  RECIP_153_S11    = 4'd13;

    // Rounded-up reciprocal of five, exact for every remainder below 153.
    localparam logic [7:0]  RECIP_5_S10      = 8'd205;

    // Four times the day offset 2472632, plus three.
    localparam logic [23:0] DAY_OFFSET_X4 = 24'd9890531;
    localparam logic [15:0] YEAR_BIAS     = 16'd6700;

    typedef struct packed {
        logic [31:0] val;
        logic [26:0] qa;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic        inv;
        logic [6:0]  b;
        logic [6:0]  d;
        logic [3:0]  m;
        logic [7:0]  rm;
        logic [4:0]  mday;
        logic [3:0]  mon;
        logic [7:0]  yr;
    } t_stage;

endpackage

// ===== rtl/epoch_seconds_to_calendar_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Converts unsigned epoch seconds to local calendar fields in a 14-stage
// pipeline of reciprocal-multiply divisions.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_ready   i_epoch_seconds
//   result    out        o_valid / i_ready   o_second .. o_invalid
//   config    in         i_cfg_we            i_cfg_wdata (zone hours)
//
// One item enters per cycle while the output is not stalled. The stages
// are six constant divisions, each an estimate stage and a correction
// stage, plus zone addition and output formatting. Reset is synchronous
// and clears all valid bits and loads a zone offset of eight hours. A
// stall holds each occupied stage, while empty stages further up still
// accept items.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [7:0]  o_years_since_1900,
    output logic        o_invalid
);

    localparam int LAST = e2c_pkg::NUM_STAGES - 1;

    logic signed [4:0] r_zone;
    logic [e2c_pkg::NUM_STAGES-1:0] r_vld;
    logic [e2c_pkg::NUM_STAGES-1:0] en;
    e2c_pkg::t_stage r_stg [e2c_pkg::NUM_STAGES];
    e2c_pkg::t_stage n_stg [e2c_pkg::NUM_STAGES];

    logic [58:0] p0;
    logic [32:0] p1;
    logic [31:0] d1;
    logic [6:0]  rem1;
    logic [48:0] p2;
    logic [27:0] p3;
    logic [26:0] d3;
    logic [6:0]  rem3;
    logic [21:0] hsum;
    logic [37:0] p5;
    logic [21:0] p6;
    logic [20:0] d6;
    logic [5:0]  rem6;
    logic [23:0] x4;
    logic [30:0] p7;
    logic [24:0] p8;
    logic [24:0] d8;
    logic [18:0] rem8;
    logic [18:0] cor8;
    logic [17:0] x5;
    logic [25:0] p9;
    logic [17:0] p10;
    logic [17:0] d10;
    logic [11:0] rem10;
    logic [11:0] cor10;
    logic [10:0] x6;
    logic [14:0] p11;
    logic [11:0] p12;
    logic [11:0] d12;
    logic [8:0]  rem12;
    logic [15:0] p13;
    logic        wrap;
    logic [15:0] yfull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= e2c_pkg::ZONE_RESET;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_wdata;
        end
    end

    always_comb begin
        en[LAST] = !r_vld[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_comb begin
        for (int k = 1; k < e2c_pkg::NUM_STAGES; k++) begin
            n_stg[k] = r_stg[k-1];
        end

        // Seconds: estimate the quotient by 60.
        n_stg[0]     = '0;
        p0           = 59'(i_epoch_seconds) * 59'(e2c_pkg::RECIP_60_S32);
        n_stg[0].val = i_epoch_seconds;
        n_stg[0].qa  = p0[58:32];

        p1   = 33'(r_stg[0].qa) * 33'(e2c_pkg::DIV_60);
        d1   = r_stg[0].val - p1[31:0];
        rem1 = d1[6:0];
        if (rem1 >= 7'(e2c_pkg::DIV_60)) begin
            n_stg[1].sec = 6'(rem1 - 7'(e2c_pkg::DIV_60));
            n_stg[1].val = 32'(r_stg[0].qa) + 32'd1;
        end else begin
            n_stg[1].sec = rem1[5:0];
            n_stg[1].val = 32'(r_stg[0].qa);
        end

        // Minutes.
        p2           = 49'(r_stg[1].val[26:0]) * 49'(e2c_pkg::RECIP_60_S27);
        n_stg[2].qa  = 27'(p2[47:27]);

        p3   = 28'(r_stg[2].qa[20:0]) * 28'(e2c_pkg::DIV_60);
        d3   = r_stg[2].val[26:0] - p3[26:0];
        rem3 = d3[6:0];
        if (rem3 >= 7'(e2c_pkg::DIV_60)) begin
            n_stg[3].min = 6'(rem3 - 7'(e2c_pkg::DIV_60));
            n_stg[3].val = 32'(r_stg[2].qa[20:0]) + 32'd1;
        end else begin
            n_stg[3].min = rem3[5:0];
            n_stg[3].val = 32'(r_stg[2].qa[20:0]);
        end

        // Zone offset on the hour count; a negative sum marks the item invalid.
        hsum         = {1'b0, r_stg[3].val[20:0]} + {{17{r_zone[4]}}, r_zone};
        n_stg[4].inv = hsum[21];
        n_stg[4].val = 32'(hsum[20:0]);

        // Hours and day count.
        p5           = 38'(r_stg[4].val[20:0]) * 38'(e2c_pkg::RECIP_24_S21);
        n_stg[5].qa  = 27'(p5[36:21]);

        p6   = 22'(r_stg[5].qa[15:0]) * 22'(e2c_pkg::DIV_24);
        d6   = r_stg[5].val[20:0] - p6[20:0];
        rem6 = d6[5:0];
        if (rem6 >= 6'(e2c_pkg::DIV_24)) begin
            n_stg[6].hour = 5'(rem6 - 6'(e2c_pkg::DIV_24));
            n_stg[6].val  = 32'(r_stg[5].qa[15:0]) + 32'd1;
        end else begin
            n_stg[6].hour = rem6[4:0];
            n_stg[6].val  = 32'(r_stg[5].qa[15:0]);
        end

        // Era: quotient by 146097 of the offset day count.
        x4           = {r_stg[6].val[21:0], 2'b00} + e2c_pkg::DAY_OFFSET_X4;
        p7           = 31'(x4) * 31'(e2c_pkg::RECIP_146097_S24);
        n_stg[7].val = 32'(x4);
        n_stg[7].qa  = 27'(p7[30:24]);

        p8   = 25'(r_stg[7].qa[6:0]) * 25'(e2c_pkg::DIV_146097);
        d8   = 25'(r_stg[7].val[23:0]) - p8;
        rem8 = d8[18:0];
        if (rem8 >= 19'(e2c_pkg::DIV_146097)) begin
            cor8       = rem8 - 19'(e2c_pkg::DIV_146097);
            n_stg[8].b = r_stg[7].qa[6:0] + 7'd1;
        end else begin
            cor8       = rem8;
            n_stg[8].b = r_stg[7].qa[6:0];
        end
        n_stg[8].val = 32'(cor8[17:2]);

        // Year within the era: quotient by 1461.
        x5           = {r_stg[8].val[15:0], 2'b11};
        p9           = 26'(x5) * 26'(e2c_pkg::RECIP_1461_S18);
        n_stg[9].val = 32'(x5);
        n_stg[9].qa  = 27'(p9[24:18]);

        p10   = 18'(r_stg[9].qa[6:0]) * 18'(e2c_pkg::DIV_1461);
        d10   = r_stg[9].val[17:0] - p10;
        rem10 = d10[11:0];
        if (rem10 >= 12'(e2c_pkg::DIV_1461)) begin
            cor10       = rem10 - 12'(e2c_pkg::DIV_1461);
            n_stg[10].d = r_stg[9].qa[6:0] + 7'd1;
        end else begin
            cor10       = rem10;
            n_stg[10].d = r_stg[9].qa[6:0];
        end
        n_stg[10].val = 32'(cor10[10:2]);

        // Month from the day within the year: quotient by 153.
        x6            = 11'(r_stg[10].val[8:0]) * 11'd5 + 11'd2;
        p11           = 15'(x6) * 15'(e2c_pkg::RECIP_153_S11);
        n_stg[11].val = 32'(x6);
        n_stg[11].qa  = 27'(p11[14:11]);

        p12   = 12'(r_stg[11].qa[3:0]) * 12'(e2c_pkg::DIV_153);
        d12   = 12'(r_stg[11].val[10:0]) - p12;
        rem12 = d12[8:0];
        if (rem12 >= 9'(e2c_pkg::DIV_153)) begin
            n_stg[12].rm = 8'(rem12 - 9'(e2c_pkg::DIV_153));
            n_stg[12].m  = r_stg[11].qa[3:0] + 4'd1;
        end else begin
            n_stg[12].rm = rem12[7:0];
            n_stg[12].m  = r_stg[11].qa[3:0];
        end

        // Output formatting.
        p13   = 16'(r_stg[12].rm) * 16'(e2c_pkg::RECIP_5_S10);
        wrap  = r_stg[12].m >= 4'd10;
        yfull = 16'(r_stg[12].b) * 16'd100 + 16'(r_stg[12].d) + 16'(wrap)
              - e2c_pkg::YEAR_BIAS;
        n_stg[13].mday = 5'(p13[15:10]) + 5'd1;
        n_stg[13].mon  = wrap ? (r_stg[12].m - 4'd10) : (r_stg[12].m + 4'd2);
        n_stg[13].yr   = yfull[7:0];
        if (r_stg[12].inv) begin
            n_stg[13].sec  = '0;
            n_stg[13].min  = '0;
            n_stg[13].hour = '0;
            n_stg[13].mday = '0;
            n_stg[13].mon  = '0;
            n_stg[13].yr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < e2c_pkg::NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < e2c_pkg::NUM_STAGES; k++) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_valid            = r_vld[LAST];
    assign o_second           = r_stg[LAST].sec;
    assign o_minute           = r_stg[LAST].min;
    assign o_hour             = r_stg[LAST].hour;
    assign o_day_of_month     = r_stg[LAST].mday;
    assign o_month            = r_stg[LAST].mon;
    assign o_years_since_1900 = r_stg[LAST].yr;
    assign o_invalid          = r_stg[LAST].inv;

`ifndef SYNTHESIS
    a_invalid_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_second == 6'd0 && o_minute == 6'd0 &&
        o_hour == 5'd0 && o_day_of_month == 5'd0 && o_month == 4'd0 &&
        o_years_since_1900 == 8'd0)
        else $error("Invalid result carries non-zero fields.");

    a_field_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid |-> o_second < 6'd60 && o_minute < 6'd60 &&
        o_hour < 5'd24 && o_month < 4'd12 && o_day_of_month != 5'd0)
        else $error("Calendar field out of range.");

    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_ready)
        else $error("Input refused although the first stage is empty.");

    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("Accepted transfer did not reach the first stage.");
`endif

endmodule

// ===== dv/epoch_seconds_to_calendar_unit_test.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit_test
// Self-checking bench for the epoch seconds to calendar unit. Epoch counts are
// sent through the input channel under several zone offsets, including the
// extremes of the five-bit register. Each one is predicted into calendar
// fields by the scoreboard. Results are compared field by field as they leave
// the block. Both channels idle at random, and one long receiver hold-off
// backs the pipeline up into the input channel.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit_test;

    localparam int CLOCK_PERIOD = 12;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 200;
    localparam int PHASE_ITEMS  = 85;

    localparam longint unsigned SECS_PER_MIN  = 60;
    localparam longint unsigned SECS_PER_HOUR = 3600;
    localparam longint unsigned SECS_PER_DAY  = 86400;
    localparam longint unsigned HOURS_PER_DAY = 24;
    localparam longint unsigned JDN_OFFSET    = 2472632;
    localparam longint unsigned DAYS_PER_400Y = 146097;
    localparam longint unsigned DAYS_PER_4Y   = 1461;
    localparam longint unsigned MONTH_SPAN    = 153;
    localparam longint unsigned YEAR_ORIGIN   = 6700;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [7:0] years_since_1900;
        logic       invalid;
    } t_calendar;

    class calendar_scoreboard;
        logic signed [4:0] zone;
        t_calendar         expected_q[$];
        bit [31:0]         source_q[$];
        int                mismatches;

        function new();
            zone       = e2c_pkg::ZONE_RESET;
            mismatches = 0;
        endfunction

        function void set_zone(logic signed [4:0] z);
            zone = z;
        endfunction

        function t_calendar to_calendar(bit [31:0] secs);
            t_calendar       r;
            longint          hours;
            longint unsigned days, a, b, c, d, e, m, wrap;
            r = '0;
            hours = longint'(secs / SECS_PER_HOUR) + longint'(zone);
            if (hours < 0) begin
                r.invalid = 1'b1;
                return r;
            end
            days = longint'(hours) / HOURS_PER_DAY;
            a    = days + JDN_OFFSET;
            b    = (a * 4 + 3) / DAYS_PER_400Y;
            c    = a - (b * DAYS_PER_400Y) / 4;
            d    = (c * 4 + 3) / DAYS_PER_4Y;
            e    = c - (d * DAYS_PER_4Y) / 4;
            m    = (e * 5 + 2) / MONTH_SPAN;
            wrap = m / 10;
            r.second           = 6'(secs % SECS_PER_MIN);
            r.minute           = 6'((secs / SECS_PER_MIN) % SECS_PER_MIN);
            r.hour             = 5'(longint'(hours) % HOURS_PER_DAY);
            r.day_of_month     = 5'(e - (m * MONTH_SPAN + 2) / 5 + 1);
            r.month            = 4'(m + 2 - 12 * wrap);
            r.years_since_1900 = 8'(b * 100 + d + wrap - YEAR_ORIGIN);
            return r;
        endfunction

        function void note_input(bit [31:0] secs);
            expected_q.insert(expected_q.size(), to_calendar(secs));
            source_q.insert(source_q.size(), secs);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(t_calendar got);
            t_calendar want;
            bit [31:0] secs;
            if (expected_q.size() == 0) begin
                report("result transfer with no expectation waiting");
                return;
            end
            want = expected_q.pop_front();
            secs = source_q.pop_front();
            if (got.second !== want.second)
                report($sformatf("second for %0d: got %0d, expected %0d",
                                 secs, got.second, want.second));
            if (got.minute !== want.minute)
                report($sformatf("minute for %0d: got %0d, expected %0d",
                                 secs, got.minute, want.minute));
            if (got.hour !== want.hour)
                report($sformatf("hour for %0d: got %0d, expected %0d",
                                 secs, got.hour, want.hour));
            if (got.day_of_month !== want.day_of_month)
                report($sformatf("day_of_month for %0d: got %0d, expected %0d",
                                 secs, got.day_of_month, want.day_of_month));
            if (got.month !== want.month)
                report($sformatf("month for %0d: got %0d, expected %0d",
                                 secs, got.month, want.month));
            if (got.years_since_1900 !== want.years_since_1900)
                report($sformatf("years_since_1900 for %0d: got %0d, expected %0d",
                                 secs, got.years_since_1900, want.years_since_1900));
            if (got.invalid !== want.invalid)
                report($sformatf("invalid for %0d: got %0d, expected %0d",
                                 secs, got.invalid, want.invalid));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_epoch_seconds;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_second;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month;
    logic [7:0]  o_years_since_1900;
    logic        o_invalid;

    calendar_scoreboard board;
    bit                 sender_rush;
    bit                 receiver_rush;
    bit                 hold_off_pending;
    int                 cycle_count;

    epoch_seconds_to_calendar_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_second           (o_second),
        .o_minute           (o_minute),
        .o_hour             (o_hour),
        .o_day_of_month     (o_day_of_month),
        .o_month            (o_month),
        .o_years_since_1900 (o_years_since_1900),
        .o_invalid          (o_invalid)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLOCK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** epoch_seconds_to_calendar_unit: FAILED **");
            $finish;
        end
    end

    function automatic int idle_cycles(bit rush);
        if (rush)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic bit [31:0] pick_seconds();
        longint unsigned day;
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: return $urandom_range(0, 20 * 3600);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
            default: begin
                day = $urandom_range(0, 49710);
                return 32'(day * SECS_PER_DAY + $urandom_range(0, 7199) - 3600);
            end
        endcase
    endfunction

    task automatic send_item(bit [31:0] secs);
        int gap;
        gap = idle_cycles(sender_rush);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (!o_ready);
        board.note_input(secs);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_zone(logic signed [4:0] z);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= z;
        board.set_zone(z);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic signed [4:0] z, bit with_hold);
        longint border;
        write_zone(z);
        if (z < 0) begin
            border = -longint'(z) * 3600;
            send_item(32'(border - 1));
            send_item(32'(border));
        end
        if (with_hold)
            hold_off_pending = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 20 == 0) begin
                sender_rush   = ($urandom_range(0, 3) == 0) || (with_hold && n < 40);
                receiver_rush = ($urandom_range(0, 3) == 0);
            end
            send_item(pick_seconds());
        end
        drain();
    endtask

    initial begin
        t_calendar got;
        int        wait_cycles;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_pending) begin
                wait_cycles      = LONG_HOLD;
                hold_off_pending = 1'b0;
            end else begin
                wait_cycles = idle_cycles(receiver_rush);
            end
            @(negedge i_clk);
            if (wait_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.second           = o_second;
            got.minute           = o_minute;
            got.hour             = o_hour;
            got.day_of_month     = o_day_of_month;
            got.month            = o_month;
            got.years_since_1900 = o_years_since_1900;
            got.invalid          = o_invalid;
            board.check_result(got);
        end
    end

    initial begin
        bit [31:0]         directed[] = '{
            32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            32'd68169600, 32'd946684799, 32'd951782400, 32'd951868800,
            32'd4107456000, 32'd4107542400, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
        };
        logic signed [4:0] zones[] = '{5'sb10000, 5'sd15, -5'sd12, 5'sd14, 5'sd0, -5'sd1};
        board           = new();
        cycle_count     = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_valid         = 1'b0;
        i_epoch_seconds = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_item(directed[k]);
        drain();

        foreach (zones[k])
            run_phase(zones[k], k == 1);
        run_phase(5'($urandom_range(0, 31)), 1'b0);
        run_phase(5'($urandom_range(0, 31)), 1'b0);

        repeat (2 * e2c_pkg::NUM_STAGES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("** epoch_seconds_to_calendar_unit: PASSED **");
        end else begin
            $display("** epoch_seconds_to_calendar_unit: FAILED **");
        end
        $finish;
    end

endmodule
